### src/assert_macros.svh
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// synchronous check, skipped while reset is held low
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tcfe_pkg.sv
// types, constants and the crc step function of the torque frame encoder
`timescale 1ns / 1ps
`default_nettype none
package tcfe_pkg;

    localparam logic [7:0]  DLE_BYTE     = 8'h90;
    localparam logic [7:0]  STX_BYTE     = 8'h02;
    localparam logic [7:0]  WRITE_OPCODE = 8'h68;
    localparam logic [7:0]  WRITE_LENGTH = 8'h04;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] NODE_RESET   = 16'h0001;
    localparam logic [15:0] INDEX_RESET  = 16'h6071;
    localparam logic [15:0] SUB_RESET    = 16'h0000;
    // stuffed frame holds 14 bytes plus at most this many doubled dle bytes
    localparam logic [3:0]  MAX_STUFF    = 4'd6;
    // byte position of the last crc byte in the unstuffed frame
    localparam logic [3:0]  LAST_POS     = 4'd13;

    typedef enum logic [1:0] {
        CFG_NODE_ID    = 2'd0,
        CFG_OBJ_INDEX  = 2'd1,
        CFG_OBJ_SUBIDX = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CRC,
        FS_PUSH
    } t_front_state;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [15:0] obj_index;
        logic [7:0]  obj_subidx;
        logic [31:0] torque;
        logic [15:0] crc;
    } t_frame;

    // eight msb-first crc steps, one data bit shifted in per step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        logic        carry;
        c = crc_in;
        for (int k = 7; k >= 0; k--) begin
            carry = c[15];
            c     = {c[14:0], data[k]};
            if (carry) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### src/tcfe_front.sv
// front end: config registers, command intake, crc and frame length check
`timescale 1ns / 1ps
`default_nettype none
module tcfe_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic                i_tvalid,
    output logic                     o_tready,
    input  wire logic [31:0]         i_torque,
    output logic                     o_push_valid,
    input  wire logic                i_push_ready,
    output tcfe_pkg::t_frame         o_frame
);

    logic [7:0]             r_node_id;
    logic [15:0]            r_obj_index;
    logic [7:0]             r_obj_subidx;
    tcfe_pkg::t_front_state r_state, n_state;
    logic [95:0]            r_stream, n_stream;
    logic [3:0]             r_cnt, n_cnt;
    tcfe_pkg::t_frame       r_frame, n_frame;
    logic [3:0]             stuff_cnt;
    logic                   drop;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id    <= tcfe_pkg::NODE_RESET[7:0];
            r_obj_index  <= tcfe_pkg::INDEX_RESET;
            r_obj_subidx <= tcfe_pkg::SUB_RESET[7:0];
        end else if (i_cfg_we) begin
            unique case (tcfe_pkg::t_cfg_index'(i_cfg_index))
                tcfe_pkg::CFG_NODE_ID:    r_node_id    <= i_cfg_data[7:0];
                tcfe_pkg::CFG_OBJ_INDEX:  r_obj_index  <= i_cfg_data;
                tcfe_pkg::CFG_OBJ_SUBIDX: r_obj_subidx <= i_cfg_data[7:0];
                tcfe_pkg::CFG_UNUSED:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcfe_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stream <= n_stream;
        r_cnt    <= n_cnt;
        r_frame  <= n_frame;
    end

    // count of bytes after the stx that will be doubled
    always_comb begin
        stuff_cnt = 4'(r_frame.node_id == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.obj_index[7:0] == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.obj_index[15:8] == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.obj_subidx == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.torque[7:0] == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.torque[15:8] == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.torque[23:16] == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.torque[31:24] == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.crc[7:0] == tcfe_pkg::DLE_BYTE)
                  + 4'(r_frame.crc[15:8] == tcfe_pkg::DLE_BYTE);
        drop = stuff_cnt > tcfe_pkg::MAX_STUFF;
    end

    always_comb begin
        n_state      = r_state;
        n_stream     = r_stream;
        n_cnt        = r_cnt;
        n_frame      = r_frame;
        o_tready     = 1'b0;
        o_push_valid = 1'b0;
        unique case (r_state)
            tcfe_pkg::FS_IDLE: begin
                o_tready = 1'b1;
                if (i_tvalid) begin
                    // crc words are second byte high, first byte low, msb first
                    n_stream = {tcfe_pkg::WRITE_LENGTH, tcfe_pkg::WRITE_OPCODE,
                                r_obj_index[7:0], r_node_id,
                                r_obj_subidx, r_obj_index[15:8],
                                i_torque[15:8], i_torque[7:0],
                                i_torque[31:24], i_torque[23:16],
                                16'h0000};
                    n_cnt              = 4'd11;
                    n_frame.node_id    = r_node_id;
                    n_frame.obj_index  = r_obj_index;
                    n_frame.obj_subidx = r_obj_subidx;
                    n_frame.torque     = i_torque;
                    n_frame.crc        = 16'h0000;
                    n_state            = tcfe_pkg::FS_CRC;
                end
            end
            tcfe_pkg::FS_CRC: begin
                n_frame.crc = tcfe_pkg::crc_byte(r_frame.crc, r_stream[95:88]);
                n_stream    = {r_stream[87:0], 8'h00};
                n_cnt       = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_state = tcfe_pkg::FS_PUSH;
                end
            end
            tcfe_pkg::FS_PUSH: begin
                // an over-long stuffed frame is dropped here
                o_push_valid = !drop;
                if (drop || i_push_ready) begin
                    n_state = tcfe_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = tcfe_pkg::FS_IDLE;
            end
        endcase
    end

    assign o_frame = r_frame;

endmodule
`default_nettype wire

### src/tcfe_queue.sv
// two-entry queue of frame descriptors between front and back
`timescale 1ns / 1ps
`default_nettype none
module tcfe_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push_valid,
    output logic                     o_push_ready,
    input  wire tcfe_pkg::t_frame    i_frame,
    output logic                     o_valid,
    input  wire logic                i_pop,
    output tcfe_pkg::t_frame         o_frame
);

    tcfe_pkg::t_frame r_entry [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != 2'd2;
    assign o_valid      = r_count != 2'd0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_valid;
    assign o_frame      = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_frame;
        end
    end

endmodule
`default_nettype wire

### src/tcfe_back.sv
// back end: walks the frame bytes, doubles dle bytes, drives the output register
`timescale 1ns / 1ps
`default_nettype none
module tcfe_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire tcfe_pkg::t_frame    i_frame,
    output logic                     o_pop,
    output logic                     o_tvalid,
    input  wire logic                i_tready,
    output logic [7:0]               o_tdata,
    output logic                     o_tlast
);

    logic [3:0] r_pos;
    logic       r_dup;
    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic       r_tlast;
    logic       load;
    logic [7:0] cur_byte;
    logic       stuff;
    logic       is_last;

    always_comb begin
        unique case (r_pos)
            4'd0:    cur_byte = tcfe_pkg::DLE_BYTE;
            4'd1:    cur_byte = tcfe_pkg::STX_BYTE;
            4'd2:    cur_byte = tcfe_pkg::WRITE_OPCODE;
            4'd3:    cur_byte = tcfe_pkg::WRITE_LENGTH;
            4'd4:    cur_byte = i_frame.node_id;
            4'd5:    cur_byte = i_frame.obj_index[7:0];
            4'd6:    cur_byte = i_frame.obj_index[15:8];
            4'd7:    cur_byte = i_frame.obj_subidx;
            4'd8:    cur_byte = i_frame.torque[7:0];
            4'd9:    cur_byte = i_frame.torque[15:8];
            4'd10:   cur_byte = i_frame.torque[23:16];
            4'd11:   cur_byte = i_frame.torque[31:24];
            4'd12:   cur_byte = i_frame.crc[7:0];
            4'd13:   cur_byte = i_frame.crc[15:8];
            default: cur_byte = 8'h00;
        endcase
    end

    // first pass over a dle byte after the stx: send it, then send it again
    assign stuff   = (r_pos > 4'd1) && (cur_byte == tcfe_pkg::DLE_BYTE) && !r_dup;
    assign is_last = (r_pos == tcfe_pkg::LAST_POS) && !stuff;
    assign load    = i_valid && (!r_tvalid || i_tready);
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 4'd0;
            r_dup    <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            if (load) begin
                r_tvalid <= 1'b1;
                r_dup    <= stuff;
                if (is_last) begin
                    r_pos <= 4'd0;
                end else if (!stuff) begin
                    r_pos <= r_pos + 4'd1;
                end
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tdata <= cur_byte;
            r_tlast <= is_last;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

endmodule
`default_nettype wire

### src/torque_command_frame_encoder.sv
// top level of the torque command frame encoder
//
//  channel   dir  handshake              payload
//  command   in   i_s_tvalid/o_s_tready  i_s_tdata[31:0] torque_value
//  frame     out  o_m_tvalid/i_m_tready  o_m_tdata[7:0] frame_byte, o_m_tlast last_byte
//  config    in   i_cfg_we               i_cfg_index, i_cfg_data
//
// a command is taken while the front end is idle, then the crc runs a byte per
// cycle over twelve bytes and the descriptor moves to the queue. the back end
// sends one line byte per cycle while the output accepts, 14 to 20 bytes per
// frame, so the output port sets the sustained rate.
// frames whose stuffed length would pass 20 bytes are dropped, no output.
// synchronous active-low reset restores node 1, index 0x6071, subindex 0.
// either side may stall; the two-entry queue decouples them.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module torque_command_frame_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] torque_value
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] frame_byte
    output logic             o_m_tlast
);

    tcfe_pkg::t_frame front_frame;
    tcfe_pkg::t_frame queue_frame;
    logic             push_valid;
    logic             push_ready;
    logic             queue_valid;
    logic             queue_pop;
    logic             cmd_take;

    // intake, crc and length check
    tcfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_tvalid     (i_s_tvalid),
        .o_tready     (o_s_tready),
        .i_torque     (i_s_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_frame      (front_frame)
    );

    // descriptor queue
    tcfe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_frame      (front_frame),
        .o_valid      (queue_valid),
        .i_pop        (queue_pop),
        .o_frame      (queue_frame)
    );

    // byte sequencer with dle doubling
    tcfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_frame  (queue_frame),
        .o_pop    (queue_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

    // command item taken at this edge
    assign cmd_take = i_s_tvalid && o_s_tready;

    // a full queue is never empty
    `ASSERT_SYNC(a_full_not_empty, i_clk, i_rst_n, !push_ready |-> queue_valid, "full but empty")
    // retiring a descriptor puts its final byte in the output register
    `ASSERT_SYNC(a_pop_last, i_clk, i_rst_n, queue_pop |=> o_m_tvalid && o_m_tlast, "no last byte")
    // the front end goes busy right after taking a command
    `ASSERT_SYNC(a_busy_after_take, i_clk, i_rst_n, cmd_take |=> !o_s_tready, "two commands taken")

endmodule
`default_nettype wire

### tb/sv/tcfe_frame_checker.sv
// frame checker: predicts the stuffed drive write frame of each command and compares bytes
`timescale 1ns / 1ps
module tcfe_frame_checker
    import tcfe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] torque_value
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  i_m_tdata,   // [7:0] frame_byte
    input  wire logic        i_m_tlast,
    output int               o_mismatches,
    output int               o_pending
);

    localparam int LINE_MAX = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_line_byte;

    logic [7:0]  node_id_q;
    logic [15:0] obj_index_q;
    logic [7:0]  obj_subidx_q;
    t_line_byte  line_q [$];
    int          bad_count = 0;
    int          bytes_seen = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // msb-first crc over one 16-bit word
    function automatic logic [15:0] crc16_word(input logic [15:0] crc_in,
                                               input logic [15:0] word);
        logic [15:0] c;
        logic        carry;
        c = crc_in;
        for (int b = 15; b >= 0; b--) begin
            carry = c[15];
            c     = {c[14:0], word[b]};
            if (carry) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void queue_frame(input logic [31:0] torque);
        logic [7:0]  raw [14];
        logic [7:0]  stuffed [$];
        logic [15:0] crc;
        t_line_byte  lb;
        raw[0]  = DLE_BYTE;
        raw[1]  = STX_BYTE;
        raw[2]  = WRITE_OPCODE;
        raw[3]  = WRITE_LENGTH;
        raw[4]  = node_id_q;
        raw[5]  = obj_index_q[7:0];
        raw[6]  = obj_index_q[15:8];
        raw[7]  = obj_subidx_q;
        raw[8]  = torque[7:0];
        raw[9]  = torque[15:8];
        raw[10] = torque[23:16];
        raw[11] = torque[31:24];
        crc = 16'h0000;
        for (int i = 2; i < 12; i += 2) begin
            crc = crc16_word(crc, {raw[i + 1], raw[i]});
        end
        crc     = crc16_word(crc, 16'h0000);
        raw[12] = crc[7:0];
        raw[13] = crc[15:8];
        stuffed.push_back(raw[0]);
        stuffed.push_back(raw[1]);
        for (int i = 2; i < 14; i++) begin
            stuffed.push_back(raw[i]);
            if (raw[i] == DLE_BYTE) begin
                stuffed.push_back(DLE_BYTE);
            end
        end
        // too many doubled dle bytes: the frame is dropped
        if (stuffed.size() <= LINE_MAX) begin
            foreach (stuffed[i]) begin
                lb.data = stuffed[i];
                lb.last = (i == stuffed.size() - 1);
                line_q.push_back(lb);
            end
        end
    endfunction

    function automatic void flag_byte(input string msg);
        bad_count++;
        if (bad_count <= 10) begin
            $display("frame byte %0d: %s", bytes_seen, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_line_byte want;
        if (!i_rst_n) begin
            node_id_q    = NODE_RESET[7:0];
            obj_index_q  = INDEX_RESET;
            obj_subidx_q = SUB_RESET[7:0];
            line_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (line_q.size() == 0) begin
                    flag_byte($sformatf("unexpected, got %02h last %0b", i_m_tdata, i_m_tlast));
                end else begin
                    want = line_q.pop_front();
                    if (want.data !== i_m_tdata || want.last !== i_m_tlast) begin
                        flag_byte($sformatf("expected %02h last %0b, got %02h last %0b",
                                            want.data, want.last, i_m_tdata, i_m_tlast));
                    end
                end
                bytes_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NODE_ID:    node_id_q    = i_cfg_data[7:0];
                    CFG_OBJ_INDEX:  obj_index_q  = i_cfg_data;
                    CFG_OBJ_SUBIDX: obj_subidx_q = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                queue_frame(i_s_tdata);
            end
        end
        o_mismatches <= bad_count;
        o_pending    <= line_q.size();
    end

endmodule

### tb/sv/tb_torque_command_frame_encoder.sv
// testbench top of the torque command frame encoder: stimulus, handshakes and verdict
`timescale 1ns / 1ps
module tb_torque_command_frame_encoder;
    import tcfe_pkg::*;

    // far above the slowest correct run: ~470 items, 20 bytes each, random stalls
    localparam int RUN_LIMIT     = 200000;
    // the front end may still be busy on a command; a dropped frame gives no byte to wait on
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 50;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    t_cfg_index  cfg_index    = CFG_NODE_ID;
    logic [15:0] cfg_data     = 16'h0000;
    logic        cmd_tvalid   = 1'b0;
    logic        cmd_tready;
    logic [31:0] cmd_tdata    = 32'h0000_0000;
    logic        frame_tvalid;
    logic        frame_tready = 1'b0;
    logic [7:0]  frame_tdata;
    logic        frame_tlast;

    // while set, neither side idles or stalls
    logic        calm         = 1'b0;
    int          cycle_count  = 0;
    int          mismatches;
    int          frames_pending;

    torque_command_frame_encoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (cmd_tvalid),
        .o_s_tready  (cmd_tready),
        .i_s_tdata   (cmd_tdata),    // [31:0] torque_value
        .o_m_tvalid  (frame_tvalid),
        .i_m_tready  (frame_tready),
        .o_m_tdata   (frame_tdata),  // [7:0] frame_byte
        .o_m_tlast   (frame_tlast)
    );

    tcfe_frame_checker u_frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (cmd_tvalid),
        .i_s_tready   (cmd_tready),
        .i_s_tdata    (cmd_tdata),
        .i_m_tvalid   (frame_tvalid),
        .i_m_tready   (frame_tready),
        .i_m_tdata    (frame_tdata),
        .i_m_tlast    (frame_tlast),
        .o_mismatches (mismatches),
        .o_pending    (frames_pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // serial side stalls about one cycle in five unless calm
    always @(posedge clk) begin
        if (calm) begin
            frame_tready <= 1'b1;
        end else begin
            frame_tready <= ($urandom_range(0, 99) >= 20);
        end
    end

    // 0x90 and the extremes show up often, so stuffing and drops get exercised
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return DLE_BYTE;
            1:       return 8'h00;
            2:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_torque();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            // small commands around zero, both signs
            4: v = 32'(int'($urandom_range(0, 2000)) - 1000);
            5: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            // random bytes replaced by dle
            6, 7: begin
                for (int b = 0; b < 4; b++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        v[8*b +: 8] = DLE_BYTE;
                    end
                end
            end
            // negative command
            8: v[31] = 1'b1;
            default: v = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        endcase
        return v;
    endfunction

    // one command item, with random idle cycles ahead of it
    task automatic send_torque(input logic [31:0] value);
        while (!calm && $urandom_range(0, 99) < 20) begin
            cmd_tvalid <= 1'b0;
            cmd_tdata  <= $urandom;
            @(posedge clk);
        end
        cmd_tvalid <= 1'b1;
        cmd_tdata  <= value;
        @(posedge clk);
        while (!cmd_tready) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // all three registers, optionally a write to the unused index first
    task automatic load_settings(input logic [15:0] node_word, input logic [15:0] index_word,
                                 input logic [15:0] sub_word, input logic with_junk);
        if (with_junk) begin
            write_reg(CFG_UNUSED, 16'($urandom));
        end
        write_reg(CFG_NODE_ID, node_word);
        write_reg(CFG_OBJ_INDEX, index_word);
        write_reg(CFG_OBJ_SUBIDX, sub_word);
        cfg_we <= 1'b0;
    endtask

    // stop sending and wait until every predicted byte is out, then let the front end settle
    task automatic drain_frames();
        cmd_tvalid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [15:0] node_word;
        logic [15:0] index_word;
        logic [15:0] sub_word;

        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes, sign handling and dle stuffing in the data bytes
        send_torque(32'h0000_0000);
        send_torque(32'h0000_0001);
        send_torque(32'hFFFF_FFFF);
        send_torque(32'h7FFF_FFFF);
        send_torque(32'h8000_0000);
        send_torque(32'h0000_0090);
        send_torque(32'h9000_0000);
        // negative command that needs stuffing
        send_torque(32'hFFFF_FF90);
        send_torque(32'h9090_9090);
        send_torque(32'h1234_5678);
        drain_frames();

        // a write to the unused index must leave the settings alone
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_we <= 1'b0;
        send_torque(32'hDEAD_BEEF);
        drain_frames();

        // lowest settings; upper data bits of the byte registers are set and must be cut off
        load_settings(16'hFF00, 16'h0000, 16'hFF00, 1'b0);
        send_torque(32'h0000_0000);
        send_torque(32'h8000_0000);
        drain_frames();

        // highest settings
        load_settings(16'h00FF, 16'hFFFF, 16'h00FF, 1'b0);
        send_torque(32'hFFFF_FFFF);
        send_torque(32'h7FFF_FFFF);
        drain_frames();

        // dle in every header byte: long frames, the first one is too long and dropped
        load_settings(16'h0090, 16'h9090, 16'h0090, 1'b0);
        send_torque(32'h9090_9090);
        send_torque(32'h0000_0000);
        send_torque(32'h0000_9090);
        drain_frames();

        // random phases, each with its own settings
        for (int phase = 0; phase < PHASES; phase++) begin
            node_word  = {8'($urandom), pick_byte()};
            index_word = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : {pick_byte(), pick_byte()};
            sub_word   = {8'($urandom), pick_byte()};
            // one phase with a dle-heavy header so drops occur among random commands
            if (phase == 6) begin
                node_word  = {8'($urandom), DLE_BYTE};
                index_word = {DLE_BYTE, DLE_BYTE};
                sub_word   = {8'($urandom), DLE_BYTE};
            end
            load_settings(node_word, index_word, sub_word, $urandom_range(0, 2) == 0);
            calm <= (phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_torque(pick_torque());
            end
            drain_frames();
        end

        if (mismatches == 0 && frames_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### torque_command_frame_encoder.f
+incdir+src
src/tcfe_pkg.sv
src/tcfe_front.sv
src/tcfe_queue.sv
src/tcfe_back.sv
src/torque_command_frame_encoder.sv
tb/sv/tcfe_frame_checker.sv
tb/sv/tb_torque_command_frame_encoder.sv
